// ===== design/odt_pkg.sv =====
// Package: types, op codes and constants for the ordered device table.
package odt_pkg;

  localparam int CAPACITY_DEF  = 16;
  localparam int READ_SPAN_DEF = 3;

  typedef enum logic [2:0] {
    OP_UPSERT    = 3'd0,
    OP_REMOVE    = 3'd1,
    OP_READ_IDX  = 3'd2,
    OP_READ_KEY  = 3'd3,
    OP_READ_SPAN = 3'd4,
    OP_READ_ALL  = 3'd5
  } op_t;

  typedef struct packed {
    logic [2:0]         op;
    logic [15:0]        key;
    logic signed [7:0]  rssi;
    logic [31:0]        capture_time;
    logic [3:0]         dev_state;
    logic [7:0]         addr_type;
    logic [47:0]        address;
    logic [31:0]        last_seen;
    logic [7:0]         index;
  } request_t;

  typedef struct packed {
    logic               found;
    logic [15:0]        out_key;
    logic signed [7:0]  out_rssi;
    logic [31:0]        out_capture_time;
    logic [3:0]         out_dev_state;
    logic [7:0]         out_addr_type;
    logic [47:0]        out_address;
    logic [31:0]        out_last_seen;
    logic [4:0]         entry_count;
    logic               last;
  } result_t;

  // stored record: key and the six payload fields
  typedef struct packed {
    logic [15:0]        key;
    logic signed [7:0]  rssi;
    logic [31:0]        capture_time;
    logic [3:0]         dev_state;
    logic [7:0]         addr_type;
    logic [47:0]        address;
    logic [31:0]        last_seen;
  } record_t;

  // per-cycle command to the cell row
  typedef struct packed {
    logic shift;    // cells ahead of the fill point take their right neighbor's record
    logic rotate;   // row rotates: head goes to the tail
    logic write;    // cell at position fill loads the new record
    logic upd;      // tail takes the head's key with the new payload
  } cell_ctl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EMIT,
    ST_DONE
  } state_t;

endpackage

// ===== design/odt_cell.sv =====
// One table cell: holds one record, loads the new record on a write and takes its neighbor's on a shift or rotate.
module odt_cell (
  input  logic               clk,
  input  odt_pkg::cell_ctl_t ctl,
  input  logic               sel_write,
  input  logic               sel_shift,
  input  logic               is_tail,
  input  odt_pkg::record_t   neighbor,
  input  odt_pkg::record_t   new_rec,
  output odt_pkg::record_t   rec
);
  always_ff @(posedge clk) begin
    if (ctl.upd && is_tail) begin
      rec.key          <= neighbor.key;
      rec.rssi         <= new_rec.rssi;
      rec.capture_time <= new_rec.capture_time;
      rec.dev_state    <= new_rec.dev_state;
      rec.addr_type    <= new_rec.addr_type;
      rec.address      <= new_rec.address;
      rec.last_seen    <= new_rec.last_seen;
    end else if (ctl.write && sel_write) begin
      rec <= new_rec;
    end else if (ctl.rotate || (ctl.shift && sel_shift)) begin
      rec <= neighbor;
    end
  end
endmodule

// ===== design/ordered_device_table_core.sv =====
// Top level: ordered device table built as a rotating row of record cells.
// The table is a ring of CAPACITY record cells kept in insertion order. A request
// is taken at a clock edge with start high and busy low. Each request turns the
// ring once (one entry seen per cycle at the head, but a remove that finds its key
// holds the ring still while it closes the gap) and then passes through a
// completion state; a single-result request's result is strobed in the first
// cycle after busy falls. Read span and read all add a second turn in which the
// entries are strobed in order as they reach the head; the last result may still
// show in the first cycle after busy falls. Results appear on result with
// result_valid high for one cycle each, the final one of a request carrying last,
// and cannot be held off.
module ordered_device_table_core #(
  parameter int CAPACITY  = odt_pkg::CAPACITY_DEF,
  parameter int READ_SPAN = odt_pkg::READ_SPAN_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  odt_pkg::request_t request,
  output logic              busy,
  output logic              result_valid,
  output odt_pkg::result_t  result
);
  localparam int PW = $clog2(CAPACITY + 1);
  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int SW = PW + 1;

  odt_pkg::state_t   state, state_next;
  odt_pkg::request_t req;
  odt_pkg::record_t  cells [CAPACITY];
  odt_pkg::record_t  hit_rec, hit_rec_next;
  odt_pkg::cell_ctl_t ctl;
  logic [PW-1:0] fill, fill_next;
  logic [PW-1:0] step, step_next;   // rotation steps done in this turn; head holds entry step
  logic          hit, hit_next;
  logic [PW-1:0] emit_cnt, emit_cnt_next;
  logic [PW-1:0] emit_end, emit_end_next;
  logic [8:0]    idx_ext;
  odt_pkg::record_t new_rec;
  logic          head_match, head_valid;
  logic          key_op;
  logic          rv_next;
  odt_pkg::result_t res_next;

  assign new_rec = '{key: req.key, rssi: req.rssi, capture_time: req.capture_time,
                     dev_state: req.dev_state, addr_type: req.addr_type,
                     address: req.address, last_seen: req.last_seen};

  // Row: cell i takes cell i+1 and the tail takes the head on rotate; on
  // compaction only the cells holding live entries from the head on move up.
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    odt_pkg::cell_ctl_t cc;
    always_comb begin
      cc = ctl;
    end
    odt_cell u_cell (
      .clk      (clk),
      .ctl      (cc),
      .sel_write(fill[IW-1:0] == IW'(g) || (CAPACITY == 1)),
      .sel_shift(SW'(g) + SW'(step) < SW'(fill)),
      .is_tail  (g == CAPACITY - 1),
      .neighbor (cells[(g + 1) % CAPACITY]),
      .new_rec  (new_rec),
      .rec      (cells[g])
    );
  end

  assign idx_ext    = {1'b0, req.index};
  assign head_valid = step < fill;
  assign head_match = head_valid && cells[0].key == req.key;
  assign key_op     = req.op == odt_pkg::OP_UPSERT || req.op == odt_pkg::OP_REMOVE
                   || req.op == odt_pkg::OP_READ_KEY;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= odt_pkg::ST_IDLE;
      fill         <= '0;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      fill         <= fill_next;
      result_valid <= rv_next;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) req <= request;
    step     <= step_next;
    hit      <= hit_next;
    hit_rec  <= hit_rec_next;
    emit_cnt <= emit_cnt_next;
    emit_end <= emit_end_next;
    result   <= res_next;
  end

  assign busy = state != odt_pkg::ST_IDLE;

  // removal: at the match the live entries behind the head move up one place
  // while the ring holds still for that cycle; the turn then goes on.
  always_comb begin
    state_next    = state;
    fill_next     = fill;
    step_next     = step;
    hit_next      = hit;
    hit_rec_next  = hit_rec;
    emit_cnt_next = emit_cnt;
    emit_end_next = emit_end;
    ctl           = '0;
    rv_next       = 1'b0;
    res_next      = result;
    res_next.entry_count = 5'(fill);
    res_next.last = 1'b1;
    unique case (state)
      odt_pkg::ST_IDLE: begin
        step_next = '0;
        hit_next  = 1'b0;
        if (start) state_next = odt_pkg::ST_SCAN;
      end
      odt_pkg::ST_SCAN: begin
        // one rotation over all cells; head = entry number step
        ctl.rotate = 1'b1;
        step_next = step + 1'b1;
        if (step == PW'(CAPACITY - 1)) begin
          step_next  = '0;
          state_next = odt_pkg::ST_DONE;
        end
        if (key_op && head_match && !hit) begin
          hit_next     = 1'b1;
          hit_rec_next = cells[0];
          if (req.op == odt_pkg::OP_UPSERT) begin
            ctl.upd = 1'b1;
            hit_rec_next.rssi         = req.rssi;
            hit_rec_next.capture_time = req.capture_time;
            hit_rec_next.dev_state    = req.dev_state;
            hit_rec_next.addr_type    = req.addr_type;
            hit_rec_next.address      = req.address;
            hit_rec_next.last_seen    = req.last_seen;
          end
          if (req.op == odt_pkg::OP_REMOVE) begin
            // drop the head and pull the rest of the live entries up by one
            ctl.rotate = 1'b0;
            ctl.shift  = 1'b1;
            step_next  = step;
            state_next = state;
          end
        end
        if ((req.op == odt_pkg::OP_READ_IDX) && head_valid && 9'(step) == idx_ext
            && idx_ext < 9'(CAPACITY)) begin
          hit_next     = 1'b1;
          hit_rec_next = cells[0];
        end
      end
      odt_pkg::ST_DONE: begin
        // settle updates, then issue single result or start emission turn
        res_next = '0;
        res_next.last = 1'b1;
        state_next = odt_pkg::ST_IDLE;
        rv_next = 1'b1;
        unique case (req.op)
          odt_pkg::OP_UPSERT: begin
            if (hit) begin
              res_next.found = 1'b1;
              {res_next.out_key, res_next.out_rssi, res_next.out_capture_time,
               res_next.out_dev_state, res_next.out_addr_type, res_next.out_address,
               res_next.out_last_seen} = hit_rec;
            end else if (fill < PW'(CAPACITY)) begin
              ctl.write = 1'b1;
              fill_next = fill + 1'b1;
              res_next.found = 1'b1;
              {res_next.out_key, res_next.out_rssi, res_next.out_capture_time,
               res_next.out_dev_state, res_next.out_addr_type, res_next.out_address,
               res_next.out_last_seen} = new_rec;
            end
          end
          odt_pkg::OP_REMOVE: begin
            if (hit) begin
              fill_next = fill - 1'b1;
              res_next.found = 1'b1;
              {res_next.out_key, res_next.out_rssi, res_next.out_capture_time,
               res_next.out_dev_state, res_next.out_addr_type, res_next.out_address,
               res_next.out_last_seen} = hit_rec;
            end
          end
          odt_pkg::OP_READ_IDX, odt_pkg::OP_READ_KEY: begin
            if (hit) begin
              res_next.found = 1'b1;
              {res_next.out_key, res_next.out_rssi, res_next.out_capture_time,
               res_next.out_dev_state, res_next.out_addr_type, res_next.out_address,
               res_next.out_last_seen} = hit_rec;
            end
          end
          odt_pkg::OP_READ_SPAN, odt_pkg::OP_READ_ALL: begin
            if (req.op == odt_pkg::OP_READ_ALL) begin
              emit_cnt_next = '0;
              emit_end_next = fill;
            end else begin
              emit_cnt_next = PW'(idx_ext);
              emit_end_next = (idx_ext + 9'(READ_SPAN) > 9'(fill)) ? fill
                            : PW'(idx_ext + 9'(READ_SPAN));
            end
            if (req.op == odt_pkg::OP_READ_ALL ? fill != '0
                : (idx_ext < 9'(fill))) begin
              rv_next    = 1'b0;
              step_next  = '0;
              state_next = odt_pkg::ST_EMIT;
            end
          end
          default: ;
        endcase
        res_next.entry_count = 5'(fill_next);
      end
      odt_pkg::ST_EMIT: begin
        // rotate once more, strobing heads in [emit_cnt, emit_end)
        ctl.rotate = 1'b1;
        res_next = '0;
        if (step >= emit_cnt && step < emit_end) begin
          rv_next = 1'b1;
          res_next.found = 1'b1;
          {res_next.out_key, res_next.out_rssi, res_next.out_capture_time,
           res_next.out_dev_state, res_next.out_addr_type, res_next.out_address,
           res_next.out_last_seen} = cells[0];
          res_next.last = (step + 1'b1 == emit_end);
        end
        res_next.entry_count = 5'(fill);
        step_next = step + 1'b1;
        if (step == PW'(CAPACITY - 1)) begin
          step_next  = '0;
          state_next = odt_pkg::ST_IDLE;
        end
      end
      default: state_next = odt_pkg::ST_IDLE;
    endcase
  end

`ifndef NO_ASSERTIONS
  a_fill_max: assert property (@(posedge clk) disable iff (rst) fill <= PW'(CAPACITY))
    else $error("fill above capacity");
  a_fill_step: assert property (@(posedge clk) disable iff (rst)
    fill != $past(fill) |-> $past(state) == odt_pkg::ST_DONE)
    else $error("fill changed outside completion");
  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    state == odt_pkg::ST_IDLE && !$past(busy) |-> !result_valid)
    else $error("result while idle");
`endif
endmodule
